// ===== rtl/rs_pkg.sv =====
// ----------------------------------------------------------------------------
// rs_pkg
// Types and constants shared by the reservoir sampler modules.
// ----------------------------------------------------------------------------
package rs_pkg;

  localparam int unsigned MAX_SLOTS = 256;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned CNT_W     = 9;

  localparam logic [39:0] SUM40_MAX = 40'hFF_FFFF_FFFF;

  localparam logic [1:0] ACT_OFFER = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [7:0] REG_MODE   = 8'd0;
  localparam logic [7:0] REG_TARGET = 8'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] item_data;
    logic [31:0] item_weight;
    logic [31:0] rand_accept;
    logic [31:0] rand_pick;
    logic [7:0]  read_slot;
  } rs_in_t;

  typedef struct packed {
    logic        stored;
    logic [7:0]  slot;
    logic [63:0] read_data;
    logic        read_valid;
    logic [8:0]  filled;
  } rs_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } rs_mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } rs_mul_rsp_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    logic [31:0] weight;
  } rs_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_READ_D,
    S_PLAIN,
    S_ACC,
    S_MW,
    S_SUM,
    S_LHS1,
    S_LHS2,
    S_SEARCH,
    S_WRITE,
    S_DONE
  } rs_state_e;

endpackage

// ===== rtl/rs_mul.sv =====
// ----------------------------------------------------------------------------
// rs_mul
// Shift-add multiplier, one bit of the second operand per cycle.
// ----------------------------------------------------------------------------
module rs_mul
  import rs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rs_mul_req_t req_i,
  output rs_mul_rsp_t rsp_o
);

  logic [127:0] a_q, a_d;
  logic [63:0]  b_q, b_d;
  logic [127:0] p_q, p_d;
  logic         run_q, run_d;

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    p_d   = p_q;
    run_d = run_q;
    if (req_i.start) begin
      a_d   = {64'h0, req_i.a};
      b_d   = req_i.b;
      p_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (b_q == '0) begin
        run_d = 1'b0;
      end else begin
        if (b_q[0]) p_d = p_q + a_q;
        a_d = {a_q[126:0], 1'b0};
        b_d = {1'b0, b_q[63:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign rsp_o.done = run_q && (b_q == '0);
  assign rsp_o.p    = p_q;

endmodule

// ===== rtl/rs_store.sv =====
// ----------------------------------------------------------------------------
// rs_store
// Item and weight memories of the reservoir, registered reads.
// ----------------------------------------------------------------------------
module rs_store
  import rs_pkg::*;
#(
  parameter int unsigned ITEM_BITS = 64
) (
  input  logic                 clk_i,
  input  rs_wr_t               wr_i,
  input  logic [ITEM_BITS-1:0] wr_item_i,
  input  logic [SLOT_W-1:0]    item_raddr_i,
  input  logic [SLOT_W-1:0]    weight_raddr_i,
  output logic [ITEM_BITS-1:0] item_rdata_o,
  output logic [31:0]          weight_rdata_o
);

  logic [ITEM_BITS-1:0] item_mem   [MAX_SLOTS];
  logic [31:0]          weight_mem [MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      item_mem[wr_i.addr]   <= wr_item_i;
      weight_mem[wr_i.addr] <= wr_i.weight;
    end
    item_rdata_o   <= item_mem[item_raddr_i];
    weight_rdata_o <= weight_mem[weight_raddr_i];
  end

endmodule

// ===== rtl/reservoir_sampler.sv =====
// ----------------------------------------------------------------------------
// reservoir_sampler
// Plain and weighted reservoir sampling over a 256-slot store.
// ----------------------------------------------------------------------------
// One item is worked at a time. A read, a clear or an offer into a free slot
// needs no multiply. A plain offer on a full store adds one multiply. A
// weighted offer on a full store runs two multiplies, and when taken with more
// than one slot in use, a pass summing m slot weights and, unless that sum is
// zero, two more multiplies and a search pass over the slots. The passes come
// from the bit-serial multiplier and the single read port of the weight
// memory. The store needs no clearing after reset.
module reservoir_sampler
  import rs_pkg::*;
#(
  parameter int unsigned ITEM_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_addr_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rs_in_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rs_out_t     out_data_o
);

  rs_state_e state_q, state_d;

  logic        mode_q;
  logic [8:0]  target_q;
  logic [8:0]  filled_q;
  logic [31:0] offered_q;
  logic [63:0] seen_q;
  logic        started_q;
  logic        out_valid_q;
  rs_out_t     out_q;
  rs_out_t     res_q;
  rs_in_t      in_q;

  logic [7:0]  vic_q;
  logic [95:0] acc_q;
  logic [40:0] q_q;
  logic [79:0] lhs_q;
  logic [39:0] t_q;
  logic [39:0] s_q;
  logic [47:0] kt_q;
  logic [8:0]  k_q;
  logic        v1_q;
  logic        vb_q;
  logic [7:0]  ka_q;
  logic [7:0]  kb_q;

  rs_mul_req_t mul_req;
  rs_mul_rsp_t mul_rsp;
  rs_wr_t      wr;
  logic [ITEM_BITS-1:0] item_rd;
  logic [31:0]          weight_rd;
  logic [63:0]          rd_ext;

  logic [8:0]  slots_m, slots_m1;
  logic        full_c;
  logic [64:0] sw_add;
  logic [63:0] sw_sat;
  logic        accept_c;
  logic [40:0] t_add, s_add;
  logic [39:0] t_sat, s_sat;
  logic        hit_c;
  logic        sum_end, search_end;
  logic        is_mul;

  rs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  rs_store #(.ITEM_BITS(ITEM_BITS)) u_store (
    .clk_i          (clk_i),
    .wr_i           (wr),
    .wr_item_i      (in_q.item_data[ITEM_BITS-1:0]),
    .item_raddr_i   (in_q.read_slot),
    .weight_raddr_i (k_q[SLOT_W-1:0]),
    .item_rdata_o   (item_rd),
    .weight_rdata_o (weight_rd)
  );

  // datapath helpers
  always_comb begin
    if (target_q == 9'd0) slots_m = 9'd1;
    else if (target_q > 9'(MAX_SLOTS)) slots_m = 9'(MAX_SLOTS);
    else slots_m = target_q;
    slots_m1 = slots_m - 9'd1;
    full_c   = filled_q >= slots_m;
    sw_add   = {1'b0, seen_q} + {33'h0, in_q.item_weight};
    sw_sat   = sw_add[64] ? '1 : sw_add[63:0];
    accept_c = acc_q < {mul_rsp.p[63:0], 32'h0};
    t_add    = {1'b0, t_q} + {9'h0, weight_rd};
    t_sat    = t_add[40] ? SUM40_MAX : t_add[39:0];
    s_add    = {1'b0, s_q} + {9'h0, weight_rd};
    s_sat    = s_add[40] ? SUM40_MAX : s_add[39:0];
    hit_c    = (kt_q >= {8'h0, s_q}) && ({kt_q - {8'h0, s_q}, 32'h0} >= lhs_q);
    sum_end    = (k_q == slots_m) && !v1_q;
    search_end = (k_q == slots_m1) && !v1_q && !vb_q;
    rd_ext   = '0;
    rd_ext[ITEM_BITS-1:0] = item_rd;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: begin
        unique case (in_q.action)
          ACT_OFFER: begin
            if (!full_c) state_d = S_WRITE;
            else if (!mode_q) state_d = S_PLAIN;
            else state_d = S_ACC;
          end
          ACT_READ: state_d = S_READ_D;
          default:  state_d = S_DONE;
        endcase
      end
      S_PLAIN: begin
        if (mul_rsp.done) begin
          state_d = (mul_rsp.p[63:32] < 32'(slots_m)) ? S_WRITE : S_DONE;
        end
      end
      S_ACC:  if (mul_rsp.done) state_d = S_MW;
      S_MW: begin
        if (mul_rsp.done) begin
          if (!accept_c) state_d = S_DONE;
          else if (slots_m == 9'd1) state_d = S_WRITE;
          else state_d = S_SUM;
        end
      end
      S_SUM:    if (sum_end) state_d = (t_q == '0) ? S_WRITE : S_LHS1;
      S_LHS1:   if (mul_rsp.done) state_d = S_LHS2;
      S_LHS2:   if (mul_rsp.done) state_d = S_SEARCH;
      S_SEARCH: if ((vb_q && hit_c) || search_end) state_d = S_WRITE;
      S_WRITE:  state_d = S_DONE;
      S_READ_D: state_d = S_DONE;
      S_DONE:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    is_mul      = 1'b0;
    mul_req.a   = '0;
    mul_req.b   = '0;
    unique case (state_q)
      S_PLAIN: begin
        is_mul    = 1'b1;
        mul_req.a = {32'h0, in_q.rand_pick};
        mul_req.b = {32'h0, offered_q};
      end
      S_ACC: begin
        is_mul    = 1'b1;
        mul_req.a = seen_q;
        mul_req.b = {32'h0, in_q.rand_accept};
      end
      S_MW: begin
        is_mul    = 1'b1;
        mul_req.a = {32'h0, in_q.item_weight};
        mul_req.b = {55'h0, slots_m};
      end
      S_LHS1: begin
        is_mul    = 1'b1;
        mul_req.a = {32'h0, in_q.rand_pick};
        mul_req.b = {55'h0, slots_m1};
      end
      S_LHS2: begin
        is_mul    = 1'b1;
        mul_req.a = {23'h0, q_q};
        mul_req.b = {24'h0, t_q};
      end
      default: is_mul = 1'b0;
    endcase
    mul_req.start = is_mul && !started_q;
    wr.we      = (state_q == S_WRITE);
    wr.addr    = vic_q;
    wr.weight  = in_q.item_weight;
    in_ready_o = (state_q == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      target_q    <= 9'(MAX_SLOTS);
      filled_q    <= '0;
      offered_q   <= '0;
      seen_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_MODE:   mode_q   <= cfg_data_i[0];
          REG_TARGET: target_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mul_req.start) started_q <= 1'b1;
      else if (mul_rsp.done) started_q <= 1'b0;
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_DECIDE) begin
        if (in_q.action == ACT_OFFER) begin
          if (offered_q != '1) offered_q <= offered_q + 32'd1;
          if (mode_q) seen_q <= sw_sat;
        end else if (in_q.action == ACT_CLEAR) begin
          filled_q  <= '0;
          offered_q <= '0;
          seen_q    <= '0;
        end
      end
      if (state_q == S_WRITE && {1'b0, vic_q} == filled_q) filled_q <= filled_q + 9'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_valid_i) in_q <= in_data_i;
      S_DECIDE: begin
        res_q.stored     <= 1'b0;
        res_q.slot       <= (in_q.action == ACT_READ) ? in_q.read_slot : '0;
        res_q.read_data  <= '0;
        res_q.read_valid <= 1'b0;
        res_q.filled     <= (in_q.action == ACT_CLEAR) ? 9'd0 : filled_q;
        vic_q <= filled_q[SLOT_W-1:0];
      end
      S_PLAIN: if (mul_rsp.done) vic_q <= mul_rsp.p[39:32];
      S_ACC:   if (mul_rsp.done) acc_q <= mul_rsp.p[95:0];
      S_MW: begin
        vic_q <= '0;
        k_q   <= '0;
        v1_q  <= 1'b0;
        t_q   <= '0;
      end
      S_SUM: begin
        v1_q <= (k_q < slots_m);
        if (k_q < slots_m) k_q <= k_q + 9'd1;
        if (v1_q) t_q <= t_sat;
        vic_q <= slots_m1[SLOT_W-1:0];
      end
      S_LHS1: if (mul_rsp.done) q_q <= mul_rsp.p[40:0];
      S_LHS2: begin
        lhs_q <= mul_rsp.p[79:0];
        k_q   <= '0;
        v1_q  <= 1'b0;
        vb_q  <= 1'b0;
        s_q   <= '0;
        kt_q  <= '0;
      end
      S_SEARCH: begin
        v1_q <= (k_q < slots_m1);
        if (k_q < slots_m1) k_q <= k_q + 9'd1;
        ka_q <= k_q[SLOT_W-1:0];
        vb_q <= v1_q;
        if (v1_q) begin
          s_q  <= s_sat;
          kt_q <= kt_q + {8'h0, t_q};
          kb_q <= ka_q;
        end
        if (vb_q && hit_c) vic_q <= kb_q;
        else vic_q <= slots_m1[SLOT_W-1:0];
      end
      S_WRITE: begin
        res_q.stored <= 1'b1;
        res_q.slot   <= vic_q;
        res_q.filled <= ({1'b0, vic_q} == filled_q) ? filled_q + 9'd1 : filled_q;
      end
      S_READ_D: begin
        if ({1'b0, in_q.read_slot} < filled_q) begin
          res_q.read_data  <= rd_ext;
          res_q.read_valid <= 1'b1;
        end
      end
      S_DONE: if (!out_valid_q || out_ready_i) out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_filled_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= 9'(MAX_SLOTS))
    else $error("filled count above slot count");

  a_victim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> ({1'b0, vic_q} < slots_m))
    else $error("victim outside slots in use");

  a_filled_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=>
      (filled_q == $past(filled_q) || filled_q == $past(filled_q) + 9'd1))
    else $error("filled count jumped on write");

  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.done)
    else $error("multiply started while one finishes");

endmodule

// ===== verif/tb_reservoir_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_reservoir_sampler
// Drives offers, reads and clears into the sampler in both modes and several
// target sizes, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module tb_reservoir_sampler;
  import rs_pkg::*;

  localparam logic [39:0] S40 = 40'hFF_FFFF_FFFF;
  localparam logic [1:0]  ACT_UNDEF = 2'd3;

  class sample_board;
    logic        mode;
    logic [8:0]  target;
    logic [63:0] items [256];
    logic [31:0] weights [256];
    logic [39:0] prefix [256];
    logic [8:0]  filled;
    logic [31:0] offered;
    logic [63:0] seen_sum;
    logic [39:0] held_sum;
    rs_out_t     pending [$];
    int          errors;
    int          n_stored;
    int          n_checked;

    function new();
      mode = 0;
      target = 9'd256;
      filled = 0;
      offered = 0;
      seen_sum = 0;
      held_sum = 0;
      errors = 0;
      n_stored = 0;
      n_checked = 0;
      for (int i = 0; i < 256; i++) begin
        items[i] = 0;
        weights[i] = 0;
        prefix[i] = 0;
      end
    endfunction

    function int unsigned in_use();
      if (target == 0) return 1;
      if (target > 256) return 256;
      return 32'(target);
    endfunction

    function void rebuild(int unsigned n);
      logic [63:0] s;
      s = 0;
      for (int k = 0; k < n && k < 256; k++) begin
        s = s + weights[k];
        if (s > {24'd0, S40}) s = {24'd0, S40};
        prefix[k] = s[39:0];
      end
      held_sum = s[39:0];
    endfunction

    function int unsigned victim_of(int unsigned m, logic [31:0] pick);
      logic [127:0] lhs;
      logic [63:0]  kt;
      logic [127:0] gap;
      if (m <= 1) return 0;
      if (held_sum == 0) return m - 1;
      lhs = 128'(64'(pick) * 64'(m - 1)) * 128'(held_sum);
      for (int unsigned k = 0; k + 1 < m; k++) begin
        kt = 64'(k + 1) * 64'(held_sum);
        if ({24'd0, prefix[k]} <= kt) begin
          gap = 128'(kt - prefix[k]) << 32;
          if (!(gap < lhs)) return k;
        end
      end
      return m - 1;
    endfunction

    function void note_item(rs_in_t x);
      rs_out_t     r;
      int unsigned m, victim;
      bit          wr;
      logic [63:0] sw;
      logic [63:0] idx;
      r = '0;
      m = in_use();
      case (x.action)
        ACT_OFFER: begin
          wr = 0;
          victim = 0;
          if (offered != 32'hFFFF_FFFF) offered++;
          sw = seen_sum + x.item_weight;
          if (sw < x.item_weight) sw = '1;
          if (filled < m) begin
            victim = 32'(filled);
            wr = 1;
          end else if (!mode) begin
            idx = (64'(x.rand_pick) * 64'(offered)) >> 32;
            if (idx < m) begin
              victim = 32'(idx);
              wr = 1;
            end
          end else if ((128'(x.rand_accept) * 128'(sw)) <
                       (128'(64'(m) * 64'(x.item_weight)) << 32)) begin
            rebuild(m);
            victim = victim_of(m, x.rand_pick);
            wr = 1;
          end
          if (mode) seen_sum = sw;
          if (wr) begin
            items[victim] = x.item_data;
            weights[victim] = x.item_weight;
            if (victim == filled) filled++;
            rebuild(filled < m ? filled : m);
            r.stored = 1;
            r.slot = victim[7:0];
            n_stored++;
          end
        end
        ACT_READ: begin
          r.slot = x.read_slot;
          if (x.read_slot < filled) begin
            r.read_data = items[x.read_slot];
            r.read_valid = 1;
          end
        end
        ACT_CLEAR: begin
          filled = 0;
          offered = 0;
          seen_sum = 0;
          held_sum = 0;
        end
        default: ;
      endcase
      r.filled = filled;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(rs_out_t got);
      rs_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.stored !== want.stored)
        $display("%0t: stored exp %h got %h", $time, want.stored, got.stored);
      if (got.slot !== want.slot)
        $display("%0t: slot exp %h got %h", $time, want.slot, got.slot);
      if (got.read_data !== want.read_data)
        $display("%0t: read_data exp %h got %h", $time, want.read_data, got.read_data);
      if (got.read_valid !== want.read_valid)
        $display("%0t: read_valid exp %h got %h", $time, want.read_valid,
                 got.read_valid);
      if (got.filled !== want.filled)
        $display("%0t: filled exp %h got %h", $time, want.filled, got.filled);
      if (got !== want) errors++;
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_we_i = 0;
  logic [7:0] cfg_addr_i = 0;
  logic [8:0] cfg_data_i = 0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  rs_in_t     in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  rs_out_t    out_data_o;

  sample_board board = new();
  int          n_offers = 0;

  reservoir_sampler dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // receiver side: random stalls per result, with quiet stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_ready_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [8:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx == REG_MODE) board.mode = val[0];
    else board.target = val;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic send(rs_in_t x, bit quiet);
    @(negedge clk_i);
    if (!quiet) begin
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(x);
    if (x.action == ACT_OFFER) n_offers++;
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  function automatic rs_in_t rand_item(int unsigned offer_pct, int unsigned maxslot);
    rs_in_t x;
    int unsigned r;
    r = $urandom_range(0, 99);
    x.action = (r < offer_pct) ? ACT_OFFER : (r < 97) ? ACT_READ :
               (r < 99) ? ACT_CLEAR : ACT_UNDEF;
    x.item_data = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: x.item_weight = 0;
      1: x.item_weight = '1;
      2: x.item_weight = $urandom_range(0, 32'h0004_0000);
      default: x.item_weight = $urandom;
    endcase
    x.rand_accept = $urandom;
    x.rand_pick = $urandom;
    x.read_slot = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                  8'($urandom_range(0, maxslot));
    return x;
  endfunction

  initial begin
    rs_in_t x;
    int     tgt;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed: fill a small store, overflow it, read edges, odd actions
    write_reg(REG_TARGET, 9'd3);
    for (int i = 0; i < 6; i++) begin
      x = '0;
      x.action = ACT_OFFER;
      x.item_data = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(i);
      x.item_weight = (i == 1) ? 32'hFFFF_FFFF : 32'(i * 32'h1_0000);
      x.rand_pick = (i == 4) ? 32'hFFFF_FFFF : 32'd0;
      x.rand_accept = 0;
      send(x, 0);
    end
    for (int i = 0; i < 4; i++) begin
      x = '0;
      x.action = ACT_READ;
      x.read_slot = (i == 3) ? 8'hFF : 8'(i);
      send(x, 0);
    end
    x = '0;
    x.action = ACT_UNDEF;
    send(x, 0);
    drain();
    write_reg(REG_MODE, 9'd1);
    for (int i = 0; i < 6; i++) begin
      x = '0;
      x.action = ACT_OFFER;
      x.item_data = 64'(100 + i);
      x.item_weight = (i < 4) ? 32'd0 : 32'hFFFF_FFFF;
      x.rand_accept = (i == 5) ? 32'hFFFF_FFFF : 32'd0;
      x.rand_pick = 32'h8000_0000;
      send(x, 0);
    end
    x = '0;
    x.action = ACT_CLEAR;
    send(x, 0);
    drain();
    write_reg(REG_TARGET, 9'd1);
    for (int i = 0; i < 3; i++) begin
      x = rand_item(100, 1);
      send(x, 0);
    end
    // pause until everything is back, then target 0 and a target above the slot count
    drain();
    write_reg(REG_TARGET, 9'd0);
    send(rand_item(100, 1), 0);
    drain();
    write_reg(REG_TARGET, 9'd511);
    write_reg(REG_MODE, 9'd0);
    // random phases across modes and sizes
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph % 5)
        0: tgt = 256;
        1: tgt = 1;
        2: tgt = $urandom_range(2, 8);
        3: tgt = $urandom_range(9, 40);
        default: tgt = $urandom_range(0, 511);
      endcase
      write_reg(REG_TARGET, 9'(tgt));
      write_reg(REG_MODE, 9'(ph & 1));
      for (int i = 0; i < 100; i++) begin
        x = rand_item(80, (tgt > 255 || tgt == 0) ? 255 : tgt);
        send(x, ($urandom_range(0, 9) < 3) || (i >= 40 && i < 50));
      end
    end
    drain();
    $display("covered %0d offers (%0d stored) and %0d checked results",
             n_offers, board.n_stored, board.n_checked);
    $display("both sampling modes, targets from 0 to 511, clears and stray actions");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
